[design/cdno_pkg.sv]
`default_nettype none

package cdno_pkg;

  localparam logic [13:0] YearMin     = 14'd1;
  localparam logic [13:0] YearMax     = 14'd9999;
  localparam logic [3:0]  MonthJan    = 4'd1;
  localparam logic [3:0]  MonthFeb    = 4'd2;
  localparam logic [3:0]  MonthDec    = 4'd12;
  localparam logic [4:0]  DayFirst    = 5'd1;
  localparam logic [4:0]  DayDecLast  = 5'd31;
  localparam logic [8:0]  DaysPerYear = 9'd365;
  localparam logic [6:0]  Hundred     = 7'd100;

  // floor(y / 100) == (y * RecipHundred) >> RecipShift for every 14-bit y
  localparam logic [12:0] RecipHundred = 13'd5243;
  localparam int          RecipShift   = 19;
  localparam int          ProdW        = 27;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the months before m of a common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    unique case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[design/calendar_date_neighbour_and_ordinal_unit.sv]
`default_nettype none

// Gregorian date unit: for each date item (year, month, day) produce the
// following and preceding dates, the zero-based day of year, the day count
// since 1 January of year 1, a leap flag, a range flag when a neighbor date
// wraps around years 1..9999, and a bad-date flag (all other fields but the
// leap flag zero then). The unit is a four-stage pipeline: stage 1 multiplies
// the year by a reciprocal of 100, stage 2 derives the century quotient,
// leap flag, month length and validity, stage 3 forms the neighbor dates,
// the day of year and the (year-1)*365 product, and stage 4 is the output
// register that sums the day number. out_valid is the stage 4 valid, so an
// accepted item passes the stage 1 to 4 registers in turn before it is
// shown; one item is accepted every cycle while out_ready stays high. Each
// stage holds its item only while everything downstream is full, so a stall
// on the output back-pressures stage by stage without loss or repetition.
module calendar_date_neighbour_and_ordinal_unit
  import cdno_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [13:0] in_year,
  input  wire logic [3:0]  in_month,
  input  wire logic [4:0]  in_day,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [13:0]      out_next_year,
  output logic [3:0]       out_next_month,
  output logic [4:0]       out_next_day,
  output logic [13:0]      out_prev_year,
  output logic [3:0]       out_prev_month,
  output logic [4:0]       out_prev_day,
  output logic [8:0]       out_day_of_year,
  output logic [21:0]      out_day_number,
  output logic             out_is_leap,
  output logic             out_range_flag,
  output logic             out_bad_date
);

  // stage enables: a stage loads when it is empty or its successor loads
  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_r, v2_r, v3_r, v4_r;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // ---------------- stage 1: capture date, reciprocal multiply ----------------
  logic [13:0]      s1_year_r;
  logic [3:0]       s1_month_r;
  logic [4:0]       s1_day_r;
  logic [ProdW-1:0] s1_prod_r;
  logic [ProdW-1:0] s1_prod_nxt;

  assign s1_prod_nxt = ProdW'(in_year) * ProdW'(RecipHundred);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_year_r  <= in_year;
      s1_month_r <= in_month;
      s1_day_r   <= in_day;
      s1_prod_r  <= s1_prod_nxt;
    end
  end

  // ---------------- stage 2: century quotient, leap, validity ----------------
  logic [7:0]  s2_q;
  logic [13:0] s2_rem;
  logic        s2_leap_nxt;
  logic [7:0]  s2_qb_nxt;
  logic [4:0]  s2_mlen_nxt;
  logic        s2_bad_nxt;

  logic [13:0] s2_year_r;
  logic [3:0]  s2_month_r;
  logic [4:0]  s2_day_r;
  logic        s2_leap_r;
  logic [7:0]  s2_qb_r;
  logic [4:0]  s2_mlen_r;
  logic        s2_bad_r;

  always_comb begin
    s2_q   = s1_prod_r[ProdW-1:RecipShift];
    s2_rem = s1_year_r - 14'(14'(s2_q) * 14'(Hundred));
    // divisible by 4 but not a century, or a century divisible by 400
    s2_leap_nxt = ((s1_year_r[1:0] == 2'd0) && (s2_rem != 14'd0)) ||
                  ((s2_rem == 14'd0) && (s2_q[1:0] == 2'd0));
    // floor((year - 1) / 100)
    s2_qb_nxt   = (s2_rem == 14'd0) ? s2_q - 8'd1 : s2_q;
    s2_mlen_nxt = month_len(s1_month_r, s2_leap_nxt);
    s2_bad_nxt  = (s1_year_r < YearMin) || (s1_year_r > YearMax) ||
                  (s1_month_r < MonthJan) || (s1_month_r > MonthDec) ||
                  (s1_day_r < DayFirst) || (s1_day_r > s2_mlen_nxt);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_year_r  <= s1_year_r;
      s2_month_r <= s1_month_r;
      s2_day_r   <= s1_day_r;
      s2_leap_r  <= s2_leap_nxt;
      s2_qb_r    <= s2_qb_nxt;
      s2_mlen_r  <= s2_mlen_nxt;
      s2_bad_r   <= s2_bad_nxt;
    end
  end

  // ---------------- stage 3: neighbors, day of year, year product ----------------
  logic [13:0] s3_ny_nxt, s3_py_nxt;
  logic [3:0]  s3_nm_nxt, s3_pm_nxt;
  logic [4:0]  s3_nd_nxt, s3_pd_nxt;
  logic        s3_wrap_nxt;
  logic [8:0]  s3_doy_nxt;
  logic [13:0] s3_yb;
  logic [22:0] s3_prod;
  logic [21:0] s3_y365_nxt;
  logic [21:0] s3_acc_nxt;

  logic [13:0] s3_ny_r, s3_py_r;
  logic [3:0]  s3_nm_r, s3_pm_r;
  logic [4:0]  s3_nd_r, s3_pd_r;
  logic        s3_wrap_r;
  logic [8:0]  s3_doy_r;
  logic [21:0] s3_y365_r;
  logic [21:0] s3_acc_r;
  logic        s3_leap_r;
  logic        s3_bad_r;

  always_comb begin
    s3_ny_nxt   = s2_year_r;
    s3_nm_nxt   = s2_month_r;
    s3_nd_nxt   = s2_day_r + 5'd1;
    s3_py_nxt   = s2_year_r;
    s3_pm_nxt   = s2_month_r;
    s3_pd_nxt   = s2_day_r - 5'd1;
    s3_wrap_nxt = 1'b0;

    // advance to the first of the next month at month end
    if (s2_day_r >= s2_mlen_r) begin
      s3_nd_nxt = DayFirst;
      if (s2_month_r == MonthDec) begin
        s3_nm_nxt = MonthJan;
        if (s2_year_r == YearMax) begin
          s3_ny_nxt   = YearMin;
          s3_wrap_nxt = 1'b1;
        end else begin
          s3_ny_nxt = s2_year_r + 14'd1;
        end
      end else begin
        s3_nm_nxt = s2_month_r + 4'd1;
      end
    end

    // step back to the last day of the previous month on the first
    if (s2_day_r <= DayFirst) begin
      if (s2_month_r == MonthJan) begin
        s3_pm_nxt = MonthDec;
        s3_pd_nxt = DayDecLast;
        if (s2_year_r == YearMin) begin
          s3_py_nxt   = YearMax;
          s3_wrap_nxt = 1'b1;
        end else begin
          s3_py_nxt = s2_year_r - 14'd1;
        end
      end else begin
        s3_pm_nxt = s2_month_r - 4'd1;
        s3_pd_nxt = month_len(s2_month_r - 4'd1, s2_leap_r);
      end
    end

    s3_doy_nxt = days_before(s2_month_r) + 9'(s2_day_r) - 9'd1 +
                 9'(s2_leap_r && (s2_month_r > MonthFeb));

    s3_yb       = s2_year_r - 14'd1;
    s3_prod     = 23'(s3_yb) * 23'(DaysPerYear);
    s3_y365_nxt = s3_prod[21:0];
    // leap days before this year plus the day of year
    s3_acc_nxt  = 22'(s3_yb[13:2]) - 22'(s2_qb_r) + 22'(s2_qb_r[7:2]) + 22'(s3_doy_nxt);
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_leap_r <= s2_leap_r;
      s3_bad_r  <= s2_bad_r;
      if (s2_bad_r) begin
        s3_ny_r   <= '0;
        s3_nm_r   <= '0;
        s3_nd_r   <= '0;
        s3_py_r   <= '0;
        s3_pm_r   <= '0;
        s3_pd_r   <= '0;
        s3_wrap_r <= 1'b0;
        s3_doy_r  <= '0;
        s3_y365_r <= '0;
        s3_acc_r  <= '0;
      end else begin
        s3_ny_r   <= s3_ny_nxt;
        s3_nm_r   <= s3_nm_nxt;
        s3_nd_r   <= s3_nd_nxt;
        s3_py_r   <= s3_py_nxt;
        s3_pm_r   <= s3_pm_nxt;
        s3_pd_r   <= s3_pd_nxt;
        s3_wrap_r <= s3_wrap_nxt;
        s3_doy_r  <= s3_doy_nxt;
        s3_y365_r <= s3_y365_nxt;
        s3_acc_r  <= s3_acc_nxt;
      end
    end
  end

  // ---------------- stage 4: day number sum, output register ----------------
  logic [21:0] s4_num_nxt;
  logic [13:0] s4_ny_r, s4_py_r;
  logic [3:0]  s4_nm_r, s4_pm_r;
  logic [4:0]  s4_nd_r, s4_pd_r;
  logic [8:0]  s4_doy_r;
  logic [21:0] s4_num_r;
  logic        s4_leap_r;
  logic        s4_wrap_r;
  logic        s4_bad_r;

  assign s4_num_nxt = s3_y365_r + s3_acc_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_ny_r   <= s3_ny_r;
      s4_nm_r   <= s3_nm_r;
      s4_nd_r   <= s3_nd_r;
      s4_py_r   <= s3_py_r;
      s4_pm_r   <= s3_pm_r;
      s4_pd_r   <= s3_pd_r;
      s4_doy_r  <= s3_doy_r;
      s4_num_r  <= s4_num_nxt;
      s4_leap_r <= s3_leap_r;
      s4_wrap_r <= s3_wrap_r;
      s4_bad_r  <= s3_bad_r;
    end
  end

  assign out_valid       = v4_r;
  assign out_next_year   = s4_ny_r;
  assign out_next_month  = s4_nm_r;
  assign out_next_day    = s4_nd_r;
  assign out_prev_year   = s4_py_r;
  assign out_prev_month  = s4_pm_r;
  assign out_prev_day    = s4_pd_r;
  assign out_day_of_year = s4_doy_r;
  assign out_day_number  = s4_num_r;
  assign out_is_leap     = s4_leap_r;
  assign out_range_flag  = s4_wrap_r;
  assign out_bad_date    = s4_bad_r;

  // ---------------- assertions ----------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v1_r && v2_r && v3_r && out_valid && !out_ready))
    else $error("input stalled while the pipeline has room");

  a_bad_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_date |->
      (out_day_number == 22'd0) && (out_day_of_year == 9'd0) && !out_range_flag &&
      (out_next_day == 5'd0) && (out_prev_day == 5'd0))
    else $error("bad date carries nonzero result fields");

  a_wrap_at_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_flag |->
      ((out_next_year == YearMin) && (out_prev_year == YearMax - 14'd1)) ||
      ((out_prev_year == YearMax) && (out_next_year == YearMin + 14'd1)) ||
      ((out_next_year == YearMin) && (out_prev_year == YearMax)))
    else $error("range flag without a year wrap");

  a_good_doy_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_date |->
      (out_day_of_year <= DaysPerYear) && (out_next_day != 5'd0) && (out_prev_day != 5'd0))
    else $error("valid date with out-of-range fields");

endmodule

`default_nettype wire
